@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the page allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TPFL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpfl assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TPFL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpfl assertion failed");

`endif

@@ rtl/core/tpfl_pkg.sv @@
// Shared types and constants of the two-region page free list.
package tpfl_pkg;

	localparam int ADDR_W  = 56;
	localparam int IDX_W   = 16;
	localparam int EPOCH_W = 8;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_REINIT = 2'd2;
	localparam logic [1:0] OP_RSVD   = 2'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OOM      = 2'd1;
	localparam logic [1:0] STAT_MISALIGN = 2'd2;
	localparam logic [1:0] STAT_RANGE    = 2'd3;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_KCOUNT = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;

	localparam logic [IDX_W-1:0]  NULL_IDX   = 16'hFFFF;
	localparam logic [ADDR_W-1:0] BASE_RST   = 56'd2147483648;
	localparam logic [IDX_W-1:0]  KCOUNT_RST = 16'd1024;
	localparam logic [ADDR_W-1:0] LIMIT_RST  = 56'd2281701376;

	typedef struct packed {
		logic [1:0] op;
		logic       kern;
		logic       aligned;
	} tpfl_item_t;

	typedef struct packed {
		logic              we;
		logic [1:0]        index;
		logic [ADDR_W-1:0] data;
	} tpfl_cfg_wr_t;

	typedef struct packed {
		logic sweep_busy;
		logic in_b;
	} tpfl_stat_t;

endpackage

@@ rtl/core/two_region_page_free_list_unit.sv @@
// A request beat is written into the queue, popped in state A and finished in state B; the result is registered.
// The back executes one request at a time, using the link RAM read that precedes each head update.
// A two-entry queue lets requests be taken while a result waits on out_stall.
// Reset: async, active low; a clearing pass over all MAX_PAGES link entries follows with in_stall high.
// The same pass runs again after every 255th reinitialize, when the epoch counter wraps.
module two_region_page_free_list_unit #(
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [tpfl_pkg::ADDR_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  operation,
	input  logic                        kernel_region,
	input  logic [tpfl_pkg::ADDR_W-1:0] page_addr,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [tpfl_pkg::ADDR_W-1:0] alloc_addr,
	output logic [tpfl_pkg::IDX_W-1:0]  free_pages
);

`include "assert_macros.svh"

	localparam int PGW = tpfl_pkg::ADDR_W - PAGE_SHIFT;
	localparam int QW  = $bits(tpfl_pkg::tpfl_item_t) + PGW;

	tpfl_pkg::tpfl_cfg_wr_t cfg;
	tpfl_pkg::tpfl_stat_t   stat;
	tpfl_pkg::tpfl_item_t   front_item, q_item;
	logic [PGW-1:0]         front_pg, q_pg;
	logic                   push, q_ready, q_valid, q_pop;
	logic [QW-1:0]          q_rdata;

	always_comb begin
		cfg.we    = cfg_we;
		cfg.index = cfg_index;
		cfg.data  = cfg_data;
	end

	tpfl_front #(.PAGE_SHIFT(PAGE_SHIFT)) u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.kernel_region (kernel_region),
		.page_addr     (page_addr),
		.q_ready       (q_ready),
		.stat          (stat),
		.push          (push),
		.item          (front_item),
		.pg            (front_pg)
	);

	tpfl_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({front_item, front_pg}),
		.ready  (q_ready),
		.valid  (q_valid),
		.rdata  (q_rdata),
		.pop    (q_pop)
	);

	assign {q_item, q_pg} = q_rdata;

	tpfl_back #(.MAX_PAGES(MAX_PAGES), .PAGE_SHIFT(PAGE_SHIFT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pg       (q_pg),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.alloc_addr (alloc_addr),
		.free_pages (free_pages),
		.stat       (stat)
	);

	`TPFL_ASSERT_IMPL(a_sweep_stalls_input, stat.sweep_busy, in_stall)
	`TPFL_ASSERT_IMPL(a_fail_has_no_addr, out_valid && status != tpfl_pkg::STAT_OK, alloc_addr == '0)
	`TPFL_ASSERT_IMPL(a_result_from_finish, $rose(out_valid), $past(stat.in_b))
	`TPFL_ASSERT_NEXT(a_finish_waits, stat.in_b && out_valid && out_stall, stat.in_b)

endmodule

@@ rtl/core/tpfl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module tpfl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/tpfl_queue.sv @@
// Two-entry queue between the classifying front and the executing back.
module tpfl_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         ready,
	output logic         valid,
	output logic [W-1:0] rdata,
	input  logic         pop
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign ready = (count_q != 2'd2);
	assign valid = (count_q != 2'd0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/tpfl_front.sv @@
// Input side: accepts request beats, decodes and classifies them for the queue.
module tpfl_front #(
	parameter int PAGE_SHIFT = 12
) (
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             operation,
	input  logic                                   kernel_region,
	input  logic [tpfl_pkg::ADDR_W-1:0]            page_addr,
	input  logic                                   q_ready,
	input  tpfl_pkg::tpfl_stat_t                   stat,
	output logic                                   push,
	output tpfl_pkg::tpfl_item_t                   item,
	output logic [tpfl_pkg::ADDR_W-PAGE_SHIFT-1:0] pg
);

	// Hold off new beats while the queue is full or the link store is being cleared.
	assign in_stall = !q_ready || stat.sweep_busy;
	assign push     = in_valid && !in_stall;

	always_comb begin
		item.op      = operation;
		item.kern    = kernel_region;
		item.aligned = (page_addr[PAGE_SHIFT-1:0] == '0);
	end

	assign pg = page_addr[tpfl_pkg::ADDR_W-1:PAGE_SHIFT];

endmodule

@@ rtl/core/tpfl_back.sv @@
// Execution side: region state, link store and the two-step alloc/free/reinit sequencer.
module tpfl_back #(
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tpfl_pkg::tpfl_cfg_wr_t                 cfg,
	input  logic                                   q_valid,
	input  tpfl_pkg::tpfl_item_t                   q_item,
	input  logic [tpfl_pkg::ADDR_W-PAGE_SHIFT-1:0] q_pg,
	output logic                                   q_pop,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [1:0]                             status,
	output logic [tpfl_pkg::ADDR_W-1:0]            alloc_addr,
	output logic [tpfl_pkg::IDX_W-1:0]             free_pages,
	output tpfl_pkg::tpfl_stat_t                   stat
);

	localparam int AW  = tpfl_pkg::ADDR_W;
	localparam int IW  = tpfl_pkg::IDX_W;
	localparam int EW  = tpfl_pkg::EPOCH_W;
	localparam int PGW = AW - PAGE_SHIFT;
	localparam int MAW = $clog2(MAX_PAGES);
	localparam int MW  = EW + IW;

	localparam logic [1:0] ST_SWEEP = 2'd0;
	localparam logic [1:0] ST_A     = 2'd1;
	localparam logic [1:0] ST_B     = 2'd2;

	localparam longint RST_BASE_PG  = longint'(tpfl_pkg::BASE_RST >> PAGE_SHIFT);
	localparam longint RST_LIMIT_PG = longint'(tpfl_pkg::LIMIT_RST >> PAGE_SHIFT);
	localparam longint RST_TOT_RAW  =
		(RST_LIMIT_PG > RST_BASE_PG) ? (RST_LIMIT_PG - RST_BASE_PG) : 0;
	localparam longint RST_TOT = (RST_TOT_RAW > MAX_PAGES) ? MAX_PAGES : RST_TOT_RAW;
	localparam longint RST_K   =
		(longint'(tpfl_pkg::KCOUNT_RST) > RST_TOT) ? RST_TOT : longint'(tpfl_pkg::KCOUNT_RST);

	logic [1:0]    state_q, state_d;
	logic [MAW-1:0] sweep_addr_q, sweep_addr_d;
	logic [EW-1:0] epoch_q, epoch_d;

	logic [AW-1:0] base_cfg_q;
	logic [IW-1:0] kcount_cfg_q;
	logic [AW-1:0] limit_cfg_q;

	logic [PGW-1:0] base_pg_q, base_pg_d;
	logic [IW-1:0]  geo_k_q, geo_k_d, geo_t_q, geo_t_d;
	logic [IW-1:0]  khead_q, khead_d, uhead_q, uhead_d;
	logic [IW-1:0]  kfresh_q, kfresh_d, ufresh_q, ufresh_d;
	logic [IW-1:0]  kcnt_q, kcnt_d, ucnt_q, ucnt_d;

	logic [1:0]     op_s1;
	logic           kern_s1;
	logic           aligned_s1;
	logic [IW-1:0]  p_s1;
	logic           fail_s1;
	logic [PGW-1:0] wide_s1;
	logic           borrow_s1;

	logic           out_valid_q, out_valid_d;
	logic [1:0]     status_q, status_d;
	logic [AW-1:0]  addr_q, addr_d;
	logic [IW-1:0]  fp_q, fp_d;

	logic           kern_sel;
	logic [IW-1:0]  head_sel, fresh_sel, cnt_sel, hi_sel, lo_sel;
	logic [IW-1:0]  pick_p;
	logic           pick_fail;
	logic [PGW:0]   sub_a, sub_b, diff;
	logic [IW-1:0]  nh, nf, nc, cur, t_new, k_new;
	logic           out_free;
	logic           mem_we, mem_re;
	logic [MAW-1:0] mem_waddr;
	logic [MW-1:0]  mem_wdata, mem_rdata;

	tpfl_ram #(.WIDTH(MW), .DEPTH(MAX_PAGES)) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (pick_p[MAW-1:0]),
		.rdata (mem_rdata)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == ST_A) && q_valid;

	// Region selection serves the popping item in A and the held item in B.
	assign kern_sel  = (state_q == ST_B) ? kern_s1 : q_item.kern;
	assign head_sel  = kern_sel ? khead_q : uhead_q;
	assign fresh_sel = kern_sel ? kfresh_q : ufresh_q;
	assign cnt_sel   = kern_sel ? kcnt_q : ucnt_q;
	assign hi_sel    = kern_sel ? geo_k_q : geo_t_q;
	assign lo_sel    = kern_sel ? '0 : geo_k_q;

	// Allocation candidate: explicit list head first, then the fresh pointer.
	always_comb begin
		pick_p    = head_sel;
		pick_fail = 1'b0;
		if (head_sel == tpfl_pkg::NULL_IDX) begin
			pick_p = fresh_sel;
			if (fresh_sel >= hi_sel) begin
				pick_fail = 1'b1;
			end
		end
		if ({1'b0, pick_p} >= (IW + 1)'(MAX_PAGES)) begin
			pick_fail = 1'b1;
		end
	end

	assign mem_re = q_pop && (q_item.op == tpfl_pkg::OP_ALLOC) && !pick_fail;

	// One page-number subtractor: region size on reinit, page offset on free.
	always_comb begin
		if (q_item.op == tpfl_pkg::OP_REINIT) begin
			sub_a = {1'b0, limit_cfg_q[AW-1:PAGE_SHIFT]};
			sub_b = {1'b0, base_cfg_q[AW-1:PAGE_SHIFT]};
		end else begin
			sub_a = {1'b0, q_pg};
			sub_b = {1'b0, base_pg_q};
		end
		diff = sub_a - sub_b;
	end

	always_comb begin
		if (borrow_s1) begin
			t_new = '0;
		end else if (wide_s1 > PGW'(MAX_PAGES)) begin
			t_new = IW'(MAX_PAGES);
		end else begin
			t_new = wide_s1[IW-1:0];
		end
		k_new = (kcount_cfg_q > t_new) ? t_new : kcount_cfg_q;
	end

	always_comb begin
		if (head_sel != tpfl_pkg::NULL_IDX) begin
			cur = head_sel;
		end else if (fresh_sel < hi_sel) begin
			cur = fresh_sel;
		end else begin
			cur = tpfl_pkg::NULL_IDX;
		end
	end

	always_comb begin
		state_d      = state_q;
		sweep_addr_d = sweep_addr_q;
		epoch_d      = epoch_q;
		base_pg_d    = base_pg_q;
		geo_k_d      = geo_k_q;
		geo_t_d      = geo_t_q;
		khead_d      = khead_q;
		uhead_d      = uhead_q;
		kfresh_d     = kfresh_q;
		ufresh_d     = ufresh_q;
		kcnt_d       = kcnt_q;
		ucnt_d       = ucnt_q;
		out_valid_d  = out_valid_q && out_stall;
		status_d     = status_q;
		addr_d       = addr_q;
		fp_d         = fp_q;
		nh           = head_sel;
		nf           = fresh_sel;
		nc           = cnt_sel;
		mem_we       = 1'b0;
		mem_waddr    = sweep_addr_q;
		mem_wdata    = {{EW{1'b0}}, tpfl_pkg::NULL_IDX};
		unique case (state_q)
			ST_SWEEP: begin
				mem_we       = 1'b1;
				sweep_addr_d = sweep_addr_q + MAW'(1);
				if (sweep_addr_q == MAW'(MAX_PAGES - 1)) begin
					sweep_addr_d = '0;
					state_d      = ST_A;
				end
			end
			ST_A: begin
				if (q_valid) begin
					state_d = ST_B;
				end
			end
			ST_B: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					state_d     = ST_A;
					status_d    = tpfl_pkg::STAT_OK;
					addr_d      = '0;
					unique case (op_s1)
						tpfl_pkg::OP_ALLOC: begin
							if (fail_s1) begin
								status_d = tpfl_pkg::STAT_OOM;
							end else begin
								// An entry is linked only if written in this epoch.
								if (mem_rdata[MW-1:IW] == epoch_q) begin
									if (mem_rdata[IW-1:0] == tpfl_pkg::NULL_IDX) begin
										nh = tpfl_pkg::NULL_IDX;
										nf = hi_sel;
									end else begin
										nh = mem_rdata[IW-1:0];
									end
								end else begin
									nh = tpfl_pkg::NULL_IDX;
									nf = p_s1 + IW'(1);
								end
								nc     = (cnt_sel != '0) ? cnt_sel - IW'(1) : cnt_sel;
								addr_d = {base_pg_q + PGW'(p_s1), {PAGE_SHIFT{1'b0}}};
							end
						end
						tpfl_pkg::OP_FREE: begin
							if (!aligned_s1) begin
								status_d = tpfl_pkg::STAT_MISALIGN;
							end else if (borrow_s1 || ((wide_s1 >> IW) != '0) ||
									(wide_s1[IW-1:0] < lo_sel) ||
									(wide_s1[IW-1:0] >= hi_sel)) begin
								status_d = tpfl_pkg::STAT_RANGE;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = wide_s1[MAW-1:0];
								mem_wdata = {epoch_q, cur};
								nh        = wide_s1[IW-1:0];
								nc        = (cnt_sel != '1) ? cnt_sel + IW'(1) : cnt_sel;
							end
						end
						tpfl_pkg::OP_REINIT: begin
							base_pg_d = base_cfg_q[AW-1:PAGE_SHIFT];
							geo_t_d   = t_new;
							geo_k_d   = k_new;
							khead_d   = tpfl_pkg::NULL_IDX;
							uhead_d   = tpfl_pkg::NULL_IDX;
							kfresh_d  = '0;
							ufresh_d  = k_new;
							kcnt_d    = k_new;
							ucnt_d    = t_new - k_new;
							// Retire the epoch; on wrap, clear the store before reuse.
							if (epoch_q == '1) begin
								epoch_d = EW'(1);
								state_d = ST_SWEEP;
							end else begin
								epoch_d = epoch_q + EW'(1);
							end
						end
						tpfl_pkg::OP_RSVD: begin
						end
					endcase
					if (op_s1 != tpfl_pkg::OP_REINIT) begin
						fp_d = nc;
						if (kern_s1) begin
							khead_d  = nh;
							kfresh_d = nf;
							kcnt_d   = nc;
						end else begin
							uhead_d  = nh;
							ufresh_d = nf;
							ucnt_d   = nc;
						end
					end else begin
						fp_d = kern_s1 ? k_new : (t_new - k_new);
					end
				end
			end
			default: begin
				state_d = ST_SWEEP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_addr_q <= '0;
			epoch_q      <= EW'(1);
			base_cfg_q   <= tpfl_pkg::BASE_RST;
			kcount_cfg_q <= tpfl_pkg::KCOUNT_RST;
			limit_cfg_q  <= tpfl_pkg::LIMIT_RST;
			base_pg_q    <= PGW'(RST_BASE_PG);
			geo_k_q      <= IW'(RST_K);
			geo_t_q      <= IW'(RST_TOT);
			khead_q      <= tpfl_pkg::NULL_IDX;
			uhead_q      <= tpfl_pkg::NULL_IDX;
			kfresh_q     <= '0;
			ufresh_q     <= IW'(RST_K);
			kcnt_q       <= IW'(RST_K);
			ucnt_q       <= IW'(RST_TOT - RST_K);
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			sweep_addr_q <= sweep_addr_d;
			epoch_q      <= epoch_d;
			base_pg_q    <= base_pg_d;
			geo_k_q      <= geo_k_d;
			geo_t_q      <= geo_t_d;
			khead_q      <= khead_d;
			uhead_q      <= uhead_d;
			kfresh_q     <= kfresh_d;
			ufresh_q     <= ufresh_d;
			kcnt_q       <= kcnt_d;
			ucnt_q       <= ucnt_d;
			out_valid_q  <= out_valid_d;
			if (cfg.we) begin
				unique case (cfg.index)
					tpfl_pkg::REG_BASE:   base_cfg_q   <= cfg.data;
					tpfl_pkg::REG_KCOUNT: kcount_cfg_q <= cfg.data[IW-1:0];
					tpfl_pkg::REG_LIMIT:  limit_cfg_q  <= cfg.data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1      <= q_item.op;
			kern_s1    <= q_item.kern;
			aligned_s1 <= q_item.aligned;
			p_s1       <= pick_p;
			fail_s1    <= pick_fail;
			wide_s1    <= diff[PGW-1:0];
			borrow_s1  <= diff[PGW];
		end
		status_q <= status_d;
		addr_q   <= addr_d;
		fp_q     <= fp_d;
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign alloc_addr = addr_q;
	assign free_pages = fp_q;

	assign stat.sweep_busy = (state_q == ST_SWEEP);
	assign stat.in_b       = (state_q == ST_B);

endmodule
